// File: sv/modular_exponentiation_top_macros.svh
// Assertion macros shared by the modular exponentiation RTL.
// Used by modexp_ctrl and modular_exponentiation_top; each expects clk and rst in scope.
`ifndef MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MODEXP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MODEXP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/modexp_pkg.sv
// Shared widths, register codes and control types of the modular exponentiation block.
// No dependencies; the modules and the testbench refer to it by scoped names.
package modexp_pkg;

  localparam int BASE_W        = 32;
  localparam int RES_W         = 31;
  localparam int CFG_W         = 32;
  localparam int EXP_WIDTH_DEF = 32;
  localparam int CNT_W         = $clog2(BASE_W);

  // Configuration register indexes.
  typedef enum logic {
    CFG_EXPONENT = 1'b0,
    CFG_MODULUS  = 1'b1
  } cfg_reg_t;

  // Control of one step of the shared modular add/double unit.
  typedef struct packed {
    logic add_en;
    logic carry_in;
  } step_ctl_t;

endpackage

// File: sv/modexp_step.sv
// Shared modular step unit: one conditional add and one doubling, each reduced once.
// Depends on modexp_pkg.
module modexp_step (
  input  modexp_pkg::step_ctl_t               ctl,
  input  logic [modexp_pkg::RES_W-1:0]        modulus,
  input  logic [modexp_pkg::RES_W-1:0]        sum_in,
  input  logic [modexp_pkg::RES_W-1:0]        dbl_in,
  output logic [modexp_pkg::RES_W-1:0]        sum_out,
  output logic [modexp_pkg::RES_W-1:0]        dbl_out
);

  logic [modexp_pkg::RES_W:0] mod_wide;
  logic [modexp_pkg::RES_W:0] add_raw;
  logic [modexp_pkg::RES_W:0] add_red;
  logic [modexp_pkg::RES_W:0] dbl_raw;
  logic [modexp_pkg::RES_W:0] dbl_red;

  assign mod_wide = {1'b0, modulus};

  // Running sum plus doubled operand; both are below the modulus, so one subtract suffices.
  always_comb begin
    add_raw = {1'b0, sum_in} + {1'b0, dbl_in};
    add_red = (add_raw >= mod_wide) ? (add_raw - mod_wide) : add_raw;
    sum_out = ctl.add_en ? add_red[modexp_pkg::RES_W-1:0] : sum_in;
  end

  // Doubling with an optional shifted-in bit, used for products and base reduction.
  always_comb begin
    dbl_raw = {dbl_in, ctl.carry_in};
    dbl_red = (dbl_raw >= mod_wide) ? (dbl_raw - mod_wide) : dbl_raw;
    dbl_out = dbl_red[modexp_pkg::RES_W-1:0];
  end

endmodule

// File: sv/modexp_ctrl.sv
// Sequencer of the exponentiation: base reduction, square-and-multiply loop, handoff.
// Depends on modexp_pkg, modexp_step and the assertion macro header.
`include "modular_exponentiation_top_macros.svh"

module modexp_ctrl #(
  parameter int EXP_WIDTH = modexp_pkg::EXP_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [modexp_pkg::BASE_W-1:0] base_value,
  input  logic [EXP_WIDTH-1:0]          exponent,
  input  logic [modexp_pkg::RES_W-1:0]  modulus,
  input  logic                          out_free,
  output logic                          done,
  output logic [modexp_pkg::RES_W-1:0]  result
);

  typedef enum logic [2:0] {
    IDLE,
    REDUCE,
    NEXT,
    MUL,
    FINISH
  } state_t;

  state_t                          state;
  logic [modexp_pkg::RES_W-1:0]    acc;
  logic [modexp_pkg::RES_W-1:0]    sq;
  logic [EXP_WIDTH-1:0]            ebits;
  logic [modexp_pkg::RES_W-1:0]    psum;
  logic [modexp_pkg::RES_W-1:0]    dbl;
  logic [modexp_pkg::RES_W-1:0]    mbits;
  logic [modexp_pkg::BASE_W-1:0]   base_sh;
  logic [modexp_pkg::CNT_W-1:0]    bit_cnt;
  logic                            to_acc;

  modexp_pkg::step_ctl_t           step_ctl;
  logic [modexp_pkg::RES_W-1:0]    step_sum;
  logic [modexp_pkg::RES_W-1:0]    step_dbl;
  logic                            reduce_last;

  // The shared unit adds in product steps and shifts base bits in during reduction.
  assign step_ctl.add_en   = (state == MUL) && mbits[0];
  assign step_ctl.carry_in = (state == REDUCE) && base_sh[modexp_pkg::BASE_W-1];

  modexp_step u_step (
    .ctl     (step_ctl),
    .modulus (modulus),
    .sum_in  (psum),
    .dbl_in  (dbl),
    .sum_out (step_sum),
    .dbl_out (step_dbl)
  );

  assign reduce_last = (bit_cnt == modexp_pkg::CNT_W'(modexp_pkg::BASE_W - 1));
  assign in_stall    = (state != IDLE);
  assign done        = (state == FINISH) && out_free;
  assign result      = acc;

  // Sequencer and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            base_sh <= base_value;
            dbl     <= '0;
            bit_cnt <= '0;
            acc     <= modexp_pkg::RES_W'(modulus != modexp_pkg::RES_W'(1));
            ebits   <= exponent;
            state   <= REDUCE;
          end
        end
        REDUCE: begin
          // Base taken modulo the modulus one bit at a time, most significant first.
          dbl     <= step_dbl;
          base_sh <= base_sh << 1;
          bit_cnt <= bit_cnt + modexp_pkg::CNT_W'(1);
          if (reduce_last) begin
            sq    <= step_dbl;
            state <= NEXT;
          end
        end
        NEXT: begin
          if (ebits == '0) begin
            state <= FINISH;
          end else begin
            psum   <= '0;
            mbits  <= sq;
            dbl    <= ebits[0] ? acc : sq;
            to_acc <= ebits[0];
            state  <= MUL;
          end
        end
        MUL: begin
          if (mbits != '0) begin
            psum  <= step_sum;
            dbl   <= step_dbl;
            mbits <= mbits >> 1;
          end else if (to_acc) begin
            // Multiply into the accumulator done; the squaring follows.
            acc    <= psum;
            psum   <= '0;
            dbl    <= sq;
            mbits  <= sq;
            to_acc <= 1'b0;
          end else begin
            sq    <= psum;
            ebits <= ebits >> 1;
            state <= NEXT;
          end
        end
        FINISH: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `MODEXP_ASSERT_NXT(a_accept_starts_reduce, in_valid && !in_stall, state == REDUCE, "accepted word did not start reduction")
  `MODEXP_ASSERT_NXT(a_mul_scan_shift, (state == MUL) && (mbits != '0), mbits == ($past(mbits) >> 1), "multiplier scan skipped a bit")

endmodule

// File: sv/modular_exponentiation_top.sv
// Channel    | Signals                               | Direction
// -----------+---------------------------------------+-----------
// input      | in_valid, in_stall, base_value        | word in
// output     | out_valid, out_stall, power_result    | word out
// config     | cfg_write, cfg_index, cfg_data        | write only
//
// One word goes through base reduction, then for each exponent bit a select step,
// the multiply if the bit is set and the squaring, all in the single shared add/double
// unit. Reset is synchronous and clears the sequencer and the output valid. A new word
// is taken once the previous one is finished; a stalled result waits in the output
// register while the next word is already accepted.
//
// Top level of the modular exponentiation block; depends on modexp_pkg, modexp_ctrl
// and the assertion macro header.
`include "modular_exponentiation_top_macros.svh"

module modular_exponentiation_top #(
  parameter int EXP_WIDTH = modexp_pkg::EXP_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [0:0]                    cfg_index,
  input  logic [modexp_pkg::CFG_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [modexp_pkg::BASE_W-1:0] base_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [modexp_pkg::RES_W-1:0]  power_result
);

  logic [EXP_WIDTH-1:0]           exponent;
  logic [modexp_pkg::RES_W-1:0]   modulus;
  logic [modexp_pkg::RES_W-1:0]   mod_eff;
  logic                           out_free;
  logic                           done;
  logic [modexp_pkg::RES_W-1:0]   result;

  // Configuration registers; only the low EXP_WIDTH exponent bits are kept.
  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= '0;
      modulus  <= modexp_pkg::RES_W'(1);
    end else if (cfg_write) begin
      if (cfg_index == modexp_pkg::CFG_EXPONENT) begin
        exponent <= cfg_data[EXP_WIDTH-1:0];
      end else begin
        modulus <= cfg_data[modexp_pkg::RES_W-1:0];
      end
    end
  end

  // A zero modulus behaves as a modulus of one.
  assign mod_eff  = (modulus == '0) ? modexp_pkg::RES_W'(1) : modulus;
  assign out_free = !out_valid || !out_stall;

  modexp_ctrl #(
    .EXP_WIDTH (EXP_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .base_value (base_value),
    .exponent   (exponent),
    .modulus    (mod_eff),
    .out_free   (out_free),
    .done       (done),
    .result     (result)
  );

  // Output register holds the finished word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid    <= 1'b1;
      power_result <= result;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `MODEXP_ASSERT_IMP(a_valid_from_done, $rose(out_valid), $past(done), "output word appeared without a finished item")
  `MODEXP_ASSERT_NXT(a_taken_clears, out_valid && !out_stall && !done, !out_valid, "taken output word was repeated")

endmodule

// File: verif/tb_modular_exponentiation_top.sv
// Self-checking testbench for modular_exponentiation_top: directed keys, then random ones.
// Depends on modexp_pkg and the RTL of modular_exponentiation_top only.
`timescale 1ns / 100ps

module tb_modular_exponentiation_top;

  localparam longint unsigned EXP_MASK    = (64'd1 << modexp_pkg::EXP_WIDTH_DEF) - 64'd1;
  localparam int              MAX_LATENCY = 34 + 65 * modexp_pkg::EXP_WIDTH_DEF;
  localparam longint          CYCLE_LIMIT = 3_000_000;
  localparam int              RANDOM_WORDS = 245;
  localparam int              STEADY_WORDS = 20;

  logic                            clk;
  logic                            rst;
  logic                            cfg_write;
  logic [0:0]                      cfg_index;
  logic [modexp_pkg::CFG_W-1:0]    cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic [modexp_pkg::BASE_W-1:0]   base_value;
  logic                            out_valid;
  logic                            out_stall;
  logic [modexp_pkg::RES_W-1:0]    power_result;

  // Key as the block holds it, mirrored at every register write.
  logic [31:0]         key_exponent;
  logic [30:0]         key_modulus;

  logic [modexp_pkg::RES_W-1:0] expected_powers[$];
  longint              cycle_count;
  int                  words_sent;
  int                  results_seen;
  int                  mismatch_count;
  int                  keys_loaded;
  bit                  idle_on;

  // Receiver idling state, owned by the receiver process.
  int                  hold_request;
  int                  long_hold_left;
  int                  stall_left;
  int                  quiet_left;

  modular_exponentiation_top DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .base_value   (base_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .power_result (power_result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Square-and-multiply with exact 64-bit products; a zero modulus acts as one.
  function automatic logic [modexp_pkg::RES_W-1:0] predict_power(logic [31:0] base,
                                                                 logic [31:0] e,
                                                                 logic [30:0] m);
    longint unsigned mod_eff;
    longint unsigned acc;
    longint unsigned sq;
    longint unsigned bits;
    mod_eff = (m == 31'd0) ? 64'd1 : {33'd0, m};
    acc     = 64'd1 % mod_eff;
    sq      = {32'd0, base} % mod_eff;
    bits    = {32'd0, e} & EXP_MASK;
    while (bits != 0) begin
      if ((bits & 64'd1) != 0)
        acc = (acc * sq) % mod_eff;
      sq   = (sq * sq) % mod_eff;
      bits = bits >> 1;
    end
    return acc[modexp_pkg::RES_W-1:0];
  endfunction

  task automatic note_failure(string what, logic [modexp_pkg::RES_W-1:0] want,
                              logic [modexp_pkg::RES_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("ERROR %s: expected %0d, got %0d (result %0d, cycle %0d)",
               what, want, got, results_seen, cycle_count);
  endtask

  // Offer one word, hold it until taken, and record its expected power.
  task automatic send_word(logic [31:0] base);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    base_value <= base;
    do @(posedge clk); while (in_stall);
    expected_powers.push_back(predict_power(base, key_exponent, key_modulus));
    words_sent++;
    @(negedge clk);
  endtask

  // Stop offering words until every expected power has been checked.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_powers.size() != 0) @(negedge clk);
  endtask

  // Write both key registers on consecutive cycles; only the low 31 data bits reach the modulus.
  task automatic program_key(logic [31:0] e, logic [31:0] mod_data);
    cfg_write <= 1'b1;
    cfg_index <= modexp_pkg::CFG_EXPONENT;
    cfg_data  <= e;
    @(negedge clk);
    cfg_index <= modexp_pkg::CFG_MODULUS;
    cfg_data  <= mod_data;
    @(negedge clk);
    cfg_write <= 1'b0;
    key_exponent = e;
    key_modulus  = mod_data[30:0];
    keys_loaded++;
  endtask

  // Pick a base that often lands on the modulus edges.
  function automatic logic [31:0] pick_base();
    logic [31:0] m;
    m = {1'b0, key_modulus};
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return (m == 0) ? 32'd1 : m - 32'd1;
      3: return m;
      4: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_exponent();
    int w;
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom;
      default: begin
        w = $urandom_range(1, 12);
        return $urandom & ((32'd1 << w) - 32'd1);
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_modulus_data();
    logic [31:0] top_bit;
    top_bit = {1'($urandom_range(0, 1)), 31'd0};
    case ($urandom_range(0, 9))
      0: return top_bit;
      1: return top_bit | 32'd1;
      2: return top_bit | 32'h7FFF_FFFF;
      3: return top_bit | $urandom_range(2, 255);
      default: return top_bit | ($urandom & 32'h7FFF_FFFF);
    endcase
  endfunction

  // Power-on key: exponent zero and modulus one give zero for any base.
  task automatic test_reset_defaults();
    send_word(32'd0);
    send_word(32'hFFFF_FFFF);
    wait_drained();
  endtask

  // Zero modulus, zero exponent and modulus one.
  task automatic test_special_keys();
    program_key(32'd5, 32'h8000_0000);
    send_word(32'd7);
    send_word(32'hFFFF_FFFF);
    wait_drained();
    program_key(32'd0, 32'd7);
    send_word(32'd0);
    send_word(32'd10);
    wait_drained();
    program_key(32'hFFFF_FFFF, 32'd1);
    send_word(32'd12345);
    wait_drained();
  endtask

  // A small textbook key pair: encrypt, then decrypt back; then exponent one, modulus two.
  task automatic test_textbook_rsa();
    program_key(32'd17, 32'd3233);
    send_word(32'd65);
    wait_drained();
    program_key(32'd2753, 32'd3233);
    send_word(32'd2790);
    wait_drained();
    program_key(32'd1, 32'd2);
    send_word(32'd3);
    wait_drained();
  endtask

  // Largest modulus and exponent, bases at and around the modulus.
  task automatic test_extreme_operands();
    program_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'd0);
    send_word(32'd1);
    send_word(32'h7FFF_FFFE);
    send_word(32'h7FFF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'hFFFF_FFFF);
    wait_drained();
    program_key(32'd1, 32'h7FFF_FFFF);
    send_word(32'hFFFF_FFFF);
    wait_drained();
    program_key(32'h8000_0000, 32'h7FFF_FFFF);
    send_word(32'd2);
    wait_drained();
  endtask

  // The receiver holds off long enough that the output register and the sequencer
  // both fill and the input stalls while words keep being offered.
  task automatic test_backpressure();
    int i;
    program_key(32'd3, 32'd1000003);
    hold_request = 3000;
    for (i = 0; i < 6; i++)
      send_word($urandom);
    wait_drained();
  endtask

  // Random keys, a few words each, with idling on both sides.
  task automatic test_random_keys(int total);
    int start;
    int n;
    int i;
    start = words_sent;
    while (words_sent - start < total) begin
      program_key(pick_exponent(), pick_modulus_data());
      n = $urandom_range(4, 14);
      for (i = 0; i < n; i++)
        send_word(pick_base());
      wait_drained();
    end
  endtask

  // Back-to-back words with no idling on either side.
  task automatic test_steady_stream(int total);
    int i;
    idle_on = 1'b0;
    program_key($urandom & 32'h0000_03FF, $urandom | 32'h4000_0000);
    for (i = 0; i < total; i++)
      send_word($urandom);
    wait_drained();
  endtask

  // Receiver: an optional long hold-off, random stall bursts and quiet stretches.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      long_hold_left = hold_request;
      hold_request   = 0;
    end
    if (long_hold_left > 0) begin
      out_stall <= 1'b1;
      long_hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (quiet_left > 0) begin
      out_stall <= 1'b0;
      quiet_left--;
    end else begin
      out_stall <= 1'b0;
      if (idle_on) begin
        if ($urandom_range(0, 3) == 0)
          quiet_left = $urandom_range(20, 300);
        else if ($urandom_range(0, 5) == 0)
          stall_left = $urandom_range(1, 17);
      end
    end
  end

  // Compare each accepted result with the oldest expected power.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_powers.size() == 0)
        note_failure("unexpected result", '0, power_result);
      else if (power_result !== expected_powers[0]) begin
        note_failure("power_result", expected_powers[0], power_result);
        void'(expected_powers.pop_front());
      end else
        void'(expected_powers.pop_front());
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_powers.size());
      $display("modular_exponentiation_top: mismatch");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = modexp_pkg::CFG_EXPONENT;
    cfg_data       = '0;
    in_valid       = 1'b0;
    base_value     = '0;
    out_stall      = 1'b0;
    key_exponent   = 32'd0;
    key_modulus    = 31'd1;
    cycle_count    = 0;
    words_sent     = 0;
    results_seen   = 0;
    mismatch_count = 0;
    keys_loaded    = 0;
    idle_on        = 1'b1;
    hold_request   = 0;
    long_hold_left = 0;
    stall_left     = 0;
    quiet_left     = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_special_keys();
    test_textbook_rsa();
    test_extreme_operands();
    test_backpressure();
    test_random_keys(RANDOM_WORDS);
    test_steady_stream(STEADY_WORDS);

    // Let any stray result show up before judging.
    while (expected_powers.size() != 0) @(posedge clk);
    repeat (MAX_LATENCY) @(posedge clk);

    if (expected_powers.size() != 0)
      mismatch_count += expected_powers.size();
    $display("Covered %0d words under %0d keys, including zero and unit moduli,",
             words_sent, keys_loaded + 1);
    $display("zero and full-width exponents, long output hold-off; %0d results, %0d errors.",
             results_seen, mismatch_count);
    if (mismatch_count == 0)
      $display("modular_exponentiation_top: match");
    else
      $display("modular_exponentiation_top: mismatch");
    $finish;
  end

endmodule
